@@ rtl/core/vms_pkg.sv @@
// Package for the von Mises equivalent stress block: payload structs, internal
// transfer structs and the fixed widths of the datapath.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package vms_pkg;

	// Width of every stress field and of the result.
	localparam int DATA_W  = 32;
	// Deviatoric normal 2a - b - c needs two extra bits, plus sign.
	localparam int NORM_W  = DATA_W + 3;
	localparam int MAG_W   = DATA_W + 2;
	localparam int HALF_W  = MAG_W / 2;
	localparam int HI_W    = MAG_W - HALF_W;
	localparam int SQ_W    = 2 * MAG_W;
	// Six squared terms, the shears weighted by 18, stay below 2^(2*DATA_W+5).
	localparam int ACC_W   = 2 * DATA_W + 5;
	localparam int ROOT_W  = DATA_W;
	localparam int SRES_W  = ROOT_W + 3;
	localparam int TRIAL_W = ACC_W + 1;
	localparam int LANES   = 6;
	localparam int NORM_LANES = 3;

	// The root saturates once the sum reaches 6 * 2^(2*DATA_W).
	localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(6) << (2 * DATA_W);

	localparam logic MODE_PLANE_STRAIN = 1'b0;
	localparam logic MODE_FULL_3D      = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] sigma_xx;
		logic signed [DATA_W-1:0] sigma_yy;
		logic signed [DATA_W-1:0] third_comp;
		logic signed [DATA_W-1:0] shear_a;
		logic signed [DATA_W-1:0] shear_b;
		logic signed [DATA_W-1:0] shear_c;
	} vms_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] equiv_stress;
		logic              saturated;
	} vms_out_t;

	typedef logic [LANES-1:0][ACC_W-1:0] vms_terms_t;

	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] acc;
	} vms_sum_t;

	typedef struct packed {
		logic              valid;
		logic              sat;
		logic [ROOT_W-1:0] root;
	} vms_root_t;

endpackage

@@ rtl/core/vms_lane.sv @@
// One squaring lane: magnitude, split partial products, sum, optional x18 weight.
// Depends on vms_pkg. Registers magnitude, partial products, square and term in turn; no reset on the payload.
`timescale 1ns / 1ps

module vms_lane #(
	parameter bit SCALED = 1'b0
) (
	input  logic                              clk,
	input  logic signed [vms_pkg::NORM_W-1:0] value,
	output logic        [vms_pkg::ACC_W-1:0]  term
);
	import vms_pkg::*;

	logic [MAG_W-1:0]    mag_s2;
	logic [2*HI_W-1:0]   pp_hh_s3;
	logic [MAG_W-1:0]    pp_hl_s3;
	logic [2*HALF_W-1:0] pp_ll_s3;
	logic [SQ_W-1:0]     sq_s4;
	logic [ACC_W-1:0]    term_s5;
	logic [HI_W-1:0]     hi;
	logic [HALF_W-1:0]   lo;

	assign hi = mag_s2[MAG_W-1:HALF_W];
	assign lo = mag_s2[HALF_W-1:0];

	always_ff @(posedge clk) begin
		mag_s2   <= value[NORM_W-1] ? MAG_W'(-value) : MAG_W'(value);
		pp_hh_s3 <= (2*HI_W)'(hi) * (2*HI_W)'(hi);
		pp_hl_s3 <= MAG_W'(hi) * MAG_W'(lo);
		pp_ll_s3 <= (2*HALF_W)'(lo) * (2*HALF_W)'(lo);
		sq_s4    <= (SQ_W'(pp_hh_s3) << (2 * HALF_W)) + (SQ_W'(pp_hl_s3) << (HALF_W + 1))
			+ SQ_W'(pp_ll_s3);
		if (SCALED) begin
			// Weight 18 as 16 + 2.
			term_s5 <= (ACC_W'(sq_s4) << 4) + (ACC_W'(sq_s4) << 1);
		end else begin
			term_s5 <= ACC_W'(sq_s4);
		end
	end

	assign term = term_s5;

endmodule

@@ rtl/core/vms_merge.sv @@
// Merging stage: adds the six lane terms in a two-level registered tree.
// Depends on vms_pkg.
`timescale 1ns / 1ps

module vms_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  vms_pkg::vms_terms_t terms,
	output vms_pkg::vms_sum_t   sum
);
	import vms_pkg::*;

	logic [ACC_W-1:0] p0_s6, p1_s6, p2_s6;
	logic [ACC_W-1:0] acc_s7;
	logic             vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s6 <= valid;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		p0_s6  <= terms[0] + terms[1];
		p1_s6  <= terms[2] + terms[3];
		p2_s6  <= terms[4] + terms[5];
		acc_s7 <= p0_s6 + p1_s6 + p2_s6;
	end

	assign sum.valid = vld_s7;
	assign sum.acc   = acc_s7;

endmodule

@@ rtl/core/vms_sqrt.sv @@
// Pipelined integer square root of sum / 6, one result bit per stage.
// Depends on vms_pkg. Takes one new operand every cycle.
`timescale 1ns / 1ps

module vms_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  vms_pkg::vms_sum_t  sum,
	output vms_pkg::vms_root_t root
);
	import vms_pkg::*;

	localparam int STAGES = ROOT_W;

	// Each stage keeps rem = sum - 6*res^2 and sres = 6*res, so the test for
	// the next bit needs no division: 6*(res + 2^i)^2 - 6*res^2 is
	// (sres << (i+1)) + (3 << (2i+1)), and the two parts never overlap.
	logic [STAGES:0]       vld_s;
	logic [STAGES:0]       sat_s;
	logic [ACC_W-1:0]      rem_s  [STAGES+1];
	logic [ROOT_W-1:0]     res_s  [STAGES+1];
	logic [SRES_W-1:0]     sres_s [STAGES];
	logic [TRIAL_W-1:0]    trial  [STAGES];
	logic [STAGES-1:0]     take;

	always_comb begin
		for (int k = 0; k < STAGES; k++) begin
			trial[k] = (TRIAL_W'(sres_s[k]) << (STAGES - k))
				| (TRIAL_W'(3) << (2 * (STAGES - 1 - k) + 1));
			take[k]  = TRIAL_W'(rem_s[k]) >= trial[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STAGES-1:0], sum.valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= sum.acc;
		res_s[0]  <= '0;
		sres_s[0] <= '0;
		sat_s[0]  <= sum.acc >= SAT_LIM;
		for (int k = 0; k < STAGES; k++) begin
			sat_s[k+1] <= sat_s[k];
			if (take[k]) begin
				rem_s[k+1] <= rem_s[k] - ACC_W'(trial[k]);
				res_s[k+1] <= res_s[k] | (ROOT_W'(1) << (STAGES - 1 - k));
			end else begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= res_s[k];
			end
			if (k < STAGES - 1) begin
				if (take[k]) begin
					sres_s[k+1] <= sres_s[k] + (SRES_W'(3) << (STAGES - k));
				end else begin
					sres_s[k+1] <= sres_s[k];
				end
			end
		end
	end

	assign root.valid = vld_s[STAGES];
	assign root.sat   = sat_s[STAGES];
	assign root.root  = res_s[STAGES];

endmodule

@@ rtl/core/von_mises_equivalent_stress.sv @@
// von Mises equivalent stress, top level.
//
// Channels: an item is taken at a rising edge with start high and busy low;
// busy stays low, so a new stress vector may enter on every cycle. The result
// appears on result for exactly one cycle, marked by result_valid, and is
// transferred at the edge that ends that cycle; the receiver cannot stall it.
// Results leave in the order the items came in.
// Pipeline: throughput is one item per cycle. Most of the depth is in the square
// root pipeline, which loads its operand in one stage and then resolves one
// result bit per stage (32 stages). It sits behind one input stage, four
// squaring stages in six parallel lanes and two adder stages, and ahead of one
// output register.
// Configuration: cfg_ready is always high; a transfer on cfg_valid writes bit 0
// of cfg_data to the analysis mode (0 plane strain, 1 full 3D). Write it only
// while no item is in flight.
// Reset: arst_n clears all valid flags, so nothing is in flight, and sets the
// mode to full 3D.
// Depends on vms_pkg, vms_lane, vms_merge and vms_sqrt.
`timescale 1ns / 1ps

module von_mises_equivalent_stress (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vms_pkg::vms_in_t  item,
	output logic              result_valid,
	output vms_pkg::vms_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import vms_pkg::*;

	logic                     mode_q;
	logic                     vld_s1;
	logic [3:0]               vld_lane_s;
	logic signed [NORM_W-1:0] lane_s1 [LANES];
	logic signed [NORM_W-1:0] lane_d  [LANES];
	logic signed [NORM_W-1:0] xx, yy, zz;
	vms_terms_t               terms;
	vms_sum_t                 sum;
	vms_root_t                root;
	vms_out_t                 out_q;
	logic                     out_vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FULL_3D;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign xx = NORM_W'(item.sigma_xx);
	assign yy = NORM_W'(item.sigma_yy);
	assign zz = NORM_W'(item.third_comp);

	// Deviatoric normals scaled by 3; in plane strain the third field is the
	// xy shear and goes to a weighted lane instead.
	always_comb begin
		if (mode_q == MODE_FULL_3D) begin
			lane_d[0] = (xx <<< 1) - yy - zz;
			lane_d[1] = (yy <<< 1) - xx - zz;
			lane_d[2] = (zz <<< 1) - xx - yy;
			lane_d[3] = NORM_W'(item.shear_a);
			lane_d[4] = NORM_W'(item.shear_b);
			lane_d[5] = NORM_W'(item.shear_c);
		end else begin
			lane_d[0] = (xx <<< 1) - yy;
			lane_d[1] = (yy <<< 1) - xx;
			lane_d[2] = '0;
			lane_d[3] = zz;
			lane_d[4] = '0;
			lane_d[5] = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < LANES; g++) begin
			lane_s1[g] <= lane_d[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_lane_s <= '0;
		end else begin
			vld_s1     <= start && !busy;
			vld_lane_s <= {vld_lane_s[2:0], vld_s1};
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		vms_lane #(
			.SCALED(g >= NORM_LANES)
		) u_lane (
			.clk  (clk),
			.value(lane_s1[g]),
			.term (terms[g])
		);
	end

	vms_merge u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (vld_lane_s[3]),
		.terms (terms),
		.sum   (sum)
	);

	vms_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.sum   (sum),
		.root  (root)
	);

	always_ff @(posedge clk) begin
		out_q.equiv_stress <= root.sat ? '1 : root.root;
		out_q.saturated    <= root.sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= root.valid;
		end
	end

	assign result       = out_q;
	assign result_valid = out_vld_q;

endmodule

@@ verif/vms_checker.sv @@
// Scoreboard for the von Mises equivalent stress block: watches the item, result and
// mode-write channels, predicts each result and compares it field by field.
// Depends on vms_pkg for the payload structs, widths and mode names.
`timescale 1ns / 1ps

module vms_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  vms_pkg::vms_in_t  item,
	input  logic              result_valid,
	input  vms_pkg::vms_out_t result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_data,
	output int                errors,
	output int                pending
);
	import vms_pkg::*;

	logic     mode;
	vms_out_t stress_q[$];

	function automatic logic [127:0] square_mag(logic signed [63:0] a);
		logic [127:0] m;
		m = (a < 0) ? 128'(-a) : 128'(a);
		return m * m;
	endfunction

	// Works on scaled deviators e = 3n - sum so that no division happens before
	// the final one: energy / 6 is the square of the equivalent stress.
	function automatic vms_out_t equiv_stress_of(vms_in_t v, logic m);
		logic signed [63:0] xx, yy, zz, total;
		logic [127:0]       energy, q, root, trial;
		vms_out_t           r;
		xx = 64'(v.sigma_xx);
		yy = 64'(v.sigma_yy);
		zz = 64'(v.third_comp);
		if (m == MODE_PLANE_STRAIN) begin
			total  = xx + yy;
			energy = square_mag(3 * xx - total) + square_mag(3 * yy - total)
				+ 18 * square_mag(zz);
		end else begin
			total  = xx + yy + zz;
			energy = square_mag(3 * xx - total) + square_mag(3 * yy - total)
				+ square_mag(3 * zz - total)
				+ 18 * (square_mag(64'(v.shear_a)) + square_mag(64'(v.shear_b))
				+ square_mag(64'(v.shear_c)));
		end
		q = energy / 6;
		if (q[127:2*DATA_W] != '0) begin
			r.equiv_stress = '1;
			r.saturated    = 1'b1;
		end else begin
			root = '0;
			for (int i = DATA_W - 1; i >= 0; i--) begin
				trial = root | (128'd1 << i);
				if (trial * trial <= q)
					root = trial;
			end
			r.equiv_stress = root[DATA_W-1:0];
			r.saturated    = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vms_out_t want;
		if (!arst_n) begin
			mode = MODE_FULL_3D;
			stress_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (result_valid) begin
				if (stress_q.size() == 0) begin
					$display("%t vms_checker: result with nothing expected, actual %h/%b",
						$time, result.equiv_stress, result.saturated);
					errors++;
				end else begin
					want = stress_q.pop_front();
					if (result.equiv_stress !== want.equiv_stress) begin
						$display("%t vms_checker: equiv_stress expected %h, actual %h",
							$time, want.equiv_stress, result.equiv_stress);
						errors++;
					end
					if (result.saturated !== want.saturated) begin
						$display("%t vms_checker: saturated expected %b, actual %b",
							$time, want.saturated, result.saturated);
						errors++;
					end
				end
			end
			// The mode seen by an item is the one in force before this edge.
			if (start && !busy)
				stress_q.push_back(equiv_stress_of(item, mode));
			if (cfg_valid && cfg_ready)
				mode = cfg_data;
			pending = stress_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
// Top of the von Mises stress testbench: clock, reset, directed and random stress
// vectors, mode writes between phases and the final verdict.
// Depends on vms_pkg, von_mises_equivalent_stress and vms_checker.
`timescale 1ns / 1ps

module tb;
	import vms_pkg::*;

	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] ONE   = 32'sh0001_0000;
	// Three equal shears of this size give exactly the largest unsaturated root.
	localparam logic signed [DATA_W-1:0] EDGE_SHEAR = 32'sd1431655765;
	localparam int RANDOM_PER_PHASE = 165;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	vms_in_t  item;
	logic     result_valid;
	vms_out_t result;
	logic     cfg_valid;
	logic     cfg_ready;
	logic     cfg_data;
	int       errors;
	int       pending;

	von_mises_equivalent_stress u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	vms_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: errors");
		$finish;
	end

	function automatic vms_in_t stress_vec(logic signed [DATA_W-1:0] xx, yy, zz, a, b, c);
		vms_in_t v;
		v.sigma_xx   = xx;
		v.sigma_yy   = yy;
		v.third_comp = zz;
		v.shear_a    = a;
		v.shear_b    = b;
		v.shear_c    = c;
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_component();
		logic signed [DATA_W-1:0] f;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: f = $urandom();
			4, 5: f = $signed($urandom_range(0, 2000)) - 1000;
			6: begin
				case ($urandom_range(0, 4))
					0: f = S_MAX;
					1: f = S_MIN;
					2: f = '0;
					3: f = -1;
					default: f = 1;
				endcase
			end
			7, 8: f = $signed($urandom()) >>> $urandom_range(1, 30);
			default: f = EDGE_SHEAR + $signed($urandom_range(0, 4)) - 2;
		endcase
		return f;
	endfunction

	function automatic vms_in_t random_stress();
		vms_in_t v;
		v = stress_vec(random_component(), random_component(), random_component(),
			random_component(), random_component(), random_component());
		// Sometimes set all three normal fields equal, a hydrostatic normal part.
		if ($urandom_range(0, 9) == 0) begin
			v.sigma_yy   = v.sigma_xx;
			v.third_comp = v.sigma_xx;
		end
		return v;
	endfunction

	// busy changes only at rising edges, so its value at the falling edge is the
	// one that the next rising edge sees.
	task automatic send_stress(vms_in_t v, int idle_pct);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Mode writes only happen with the pipeline empty.
	task automatic write_mode(logic m);
		logic taken;
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int idle_pct;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 3D, the mode after reset.
		send_stress(stress_vec('0, '0, '0, '0, '0, '0), 0);
		send_stress(stress_vec(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX), 0);
		send_stress(stress_vec(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN), 0);
		send_stress(stress_vec(S_MAX, S_MIN, '0, S_MIN, S_MAX, -1), 0);
		send_stress(stress_vec(32'sd123456, 32'sd123456, 32'sd123456, '0, '0, '0), 0);
		send_stress(stress_vec('0, '0, '0, ONE, '0, '0), 0);
		send_stress(stress_vec('0, '0, '0, EDGE_SHEAR, EDGE_SHEAR, EDGE_SHEAR), 0);
		send_stress(stress_vec(1, '0, '0, EDGE_SHEAR, EDGE_SHEAR, EDGE_SHEAR), 0);
		send_stress(stress_vec('0, '0, '0, EDGE_SHEAR + 1, EDGE_SHEAR + 1,
			EDGE_SHEAR + 1), 0);
		send_stress(stress_vec(ONE, '0, '0, '0, '0, '0), 0);
		send_stress(stress_vec(-1, 1, '0, '0, '0, '0), 0);

		// Plane strain: the shear lanes carry junk that must have no effect.
		write_mode(MODE_PLANE_STRAIN);
		send_stress(stress_vec('0, '0, '0, S_MAX, S_MIN, -1), 0);
		send_stress(stress_vec(S_MAX, S_MIN, S_MIN, 32'sd77, S_MAX, S_MIN), 0);
		send_stress(stress_vec(S_MIN, S_MIN, '0, '0, '0, '0), 0);
		send_stress(stress_vec('0, '0, S_MIN, S_MAX, S_MAX, S_MAX), 0);
		send_stress(stress_vec(ONE, '0, '0, '0, '0, '0), 0);
		send_stress(stress_vec(S_MAX, S_MAX, S_MAX, '0, '0, '0), 0);
		send_stress(stress_vec(S_MIN, S_MAX, S_MAX, -1, -1, -1), 0);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
			write_mode(MODE_FULL_3D);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_stress(random_stress(), idle_pct);
			write_mode(MODE_PLANE_STRAIN);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_stress(random_stress(), idle_pct);
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
